// ===== rtl/crypto_bitmanip_alu_unit_defines.svh =====
// Assertion macros shared by the bit-manipulation ALU checker.
// No dependencies; include by bare file name.
`ifndef CRYPTO_BITMANIP_ALU_UNIT_DEFINES_SVH
`define CRYPTO_BITMANIP_ALU_UNIT_DEFINES_SVH

// pre implies post in the same cycle
`define CBA_ASSERT_IMPLY(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// pre implies post at a later edge
`define CBA_ASSERT_DELAY2(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> ##2 (post)) \
      else $error(msg);

// cond holds at every edge out of reset
`define CBA_ASSERT_ALWAYS(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

`endif

// ===== rtl/cba_pkg.sv =====
// Package for the bit-manipulation ALU: opcodes, beat payload types and
// bit-permutation helper functions. No dependencies.
`timescale 1ns / 1ps

package cba_pkg;

   localparam int XLEN = 64;
   localparam int WLEN = 32;

   localparam logic [3:0] OP_ANDN  = 4'd0;
   localparam logic [3:0] OP_ORN   = 4'd1;
   localparam logic [3:0] OP_XNOR  = 4'd2;
   localparam logic [3:0] OP_ROL   = 4'd3;
   localparam logic [3:0] OP_ROR   = 4'd4;
   localparam logic [3:0] OP_RORI  = 4'd5;
   localparam logic [3:0] OP_REV8  = 4'd6;
   localparam logic [3:0] OP_BREV8 = 4'd7;
   localparam logic [3:0] OP_PACK  = 4'd8;
   localparam logic [3:0] OP_PACKH = 4'd9;
   localparam logic [3:0] OP_PACKW = 4'd10;
   localparam logic [3:0] OP_ROLW  = 4'd11;
   localparam logic [3:0] OP_RORW  = 4'd12;
   localparam logic [3:0] OP_RORIW = 4'd13;
   localparam logic [3:0] OP_ZIP   = 4'd14;
   localparam logic [3:0] OP_UNZIP = 4'd15;

   typedef struct packed {
      logic [3:0]      opcode;
      logic [XLEN-1:0] operand_a;
      logic [XLEN-1:0] operand_b;
      logic [5:0]      shift_immediate;
   } req_payload_type;

   typedef struct packed {
      logic [XLEN-1:0] result_value;
      logic            illegal;
   } rsp_payload_type;

   function automatic logic [XLEN-1:0] rotr64(input logic [XLEN-1:0] v,
                                              input logic [5:0] s);
      logic [2*XLEN-1:0] dbl;
      dbl = {v, v} >> s;
      return dbl[XLEN-1:0];
   endfunction

   function automatic logic [WLEN-1:0] rotr32(input logic [WLEN-1:0] v,
                                              input logic [4:0] s);
      logic [2*WLEN-1:0] dbl;
      dbl = {v, v} >> s;
      return dbl[WLEN-1:0];
   endfunction

   function automatic logic [XLEN-1:0] sext32(input logic [WLEN-1:0] v);
      return {{WLEN{v[WLEN-1]}}, v};
   endfunction

   function automatic logic [XLEN-1:0] rev8_64(input logic [XLEN-1:0] v);
      logic [XLEN-1:0] r;
      for (int i = 0; i < 8; i++) begin
         r[8*i +: 8] = v[8*(7-i) +: 8];
      end
      return r;
   endfunction

   function automatic logic [XLEN-1:0] brev8_64(input logic [XLEN-1:0] v);
      logic [XLEN-1:0] r;
      for (int i = 0; i < 8; i++) begin
         for (int b = 0; b < 8; b++) begin
            r[8*i + b] = v[8*i + 7 - b];
         end
      end
      return r;
   endfunction

   function automatic logic [WLEN-1:0] zip32(input logic [WLEN-1:0] v);
      logic [WLEN-1:0] r;
      for (int i = 0; i < 16; i++) begin
         r[2*i]     = v[i];
         r[2*i + 1] = v[i + 16];
      end
      return r;
   endfunction

   function automatic logic [WLEN-1:0] unzip32(input logic [WLEN-1:0] v);
      logic [WLEN-1:0] r;
      for (int i = 0; i < 16; i++) begin
         r[i]      = v[2*i];
         r[i + 16] = v[2*i + 1];
      end
      return r;
   endfunction

endpackage

// ===== rtl/cba_exec.sv =====
// Combinational datapath of the bit-manipulation ALU: decodes one beat and
// forms the result and illegal flag. Depends on cba_pkg.
`timescale 1ns / 1ps

module cba_exec (
   input  cba_pkg::req_payload_type req,
   input  logic                     wide_mode,
   output cba_pkg::rsp_payload_type rsp
);
   import cba_pkg::*;

   logic [XLEN-1:0] mask;
   logic [XLEN-1:0] a;
   logic [XLEN-1:0] b;
   logic [WLEN-1:0] a_lo;
   logic [XLEN-1:0] res;
   logic            bad;

   assign mask = wide_mode ? {XLEN{1'b1}} : {{WLEN{1'b0}}, {WLEN{1'b1}}};
   assign a    = req.operand_a & mask;
   assign b    = req.operand_b & mask;
   assign a_lo = a[WLEN-1:0];

   always_comb begin
      res = '0;
      bad = 1'b0;
      case (req.opcode)
         OP_ANDN:  res = a & ~b;
         OP_ORN:   res = a | ~b;
         OP_XNOR:  res = ~(a ^ b);
         OP_ROL: begin
            // rotate left as a right rotate by the negated amount
            if (wide_mode) res = rotr64(a, 6'd0 - b[5:0]);
            else           res = {{WLEN{1'b0}}, rotr32(a_lo, 5'd0 - b[4:0])};
         end
         OP_ROR: begin
            if (wide_mode) res = rotr64(a, b[5:0]);
            else           res = {{WLEN{1'b0}}, rotr32(a_lo, b[4:0])};
         end
         OP_RORI: begin
            if (wide_mode)                   res = rotr64(a, req.shift_immediate);
            else if (req.shift_immediate[5]) bad = 1'b1;
            else res = {{WLEN{1'b0}}, rotr32(a_lo, req.shift_immediate[4:0])};
         end
         OP_REV8: begin
            if (wide_mode) res = rev8_64(a);
            else           res = rev8_64({a_lo, {WLEN{1'b0}}});
         end
         OP_BREV8: res = brev8_64(a);
         OP_PACK: begin
            if (wide_mode) res = {b[WLEN-1:0], a[WLEN-1:0]};
            else           res = {{WLEN{1'b0}}, b[15:0], a[15:0]};
         end
         OP_PACKH: res = {{(XLEN-16){1'b0}}, b[7:0], a[7:0]};
         OP_PACKW: begin
            if (wide_mode) res = sext32({b[15:0], a[15:0]});
            else           bad = 1'b1;
         end
         OP_ROLW: begin
            if (wide_mode) res = sext32(rotr32(a_lo, 5'd0 - b[4:0]));
            else           bad = 1'b1;
         end
         OP_RORW: begin
            if (wide_mode) res = sext32(rotr32(a_lo, b[4:0]));
            else           bad = 1'b1;
         end
         OP_RORIW: begin
            if (wide_mode) res = sext32(rotr32(a_lo, req.shift_immediate[4:0]));
            else           bad = 1'b1;
         end
         OP_ZIP: begin
            if (wide_mode) bad = 1'b1;
            else           res = {{WLEN{1'b0}}, zip32(a_lo)};
         end
         OP_UNZIP: begin
            if (wide_mode) bad = 1'b1;
            else           res = {{WLEN{1'b0}}, unzip32(a_lo)};
         end
         default: begin
            res = '0;
            bad = 1'b1;
         end
      endcase
   end

   // drop the result on an illegal beat
   assign rsp.result_value = bad ? '0 : (res & mask);
   assign rsp.illegal      = bad;

endmodule

// ===== rtl/crypto_bitmanip_alu_unit.sv =====
// Top level of the scalar crypto bit-manipulation ALU: input register,
// datapath, result register and the width-mode register. Depends on cba_pkg.
//
// Usage:
//   Command channel: drive req_payload with start high; the beat is taken at
//   any rising edge where start is high and busy is low. busy stays low, so
//   a new beat may be issued every cycle.
//   Result channel: rsp_valid pulses for one cycle with rsp_payload once the
//   command beat has passed the input register and then the result
//   register. Results come out in order, one per command, at a sustained
//   rate of one per cycle.
//   The receiver cannot stall: each result is shown for a single cycle.
//   Configuration: csr_wr_en with csr_wr_data writes wide_mode (1 = 64-bit,
//   0 = 32-bit). Write it only while no command is in flight.
//   Reset (synchronous, active high) drops any beats in flight and sets
//   wide_mode to 64-bit.
//   The datapath between the two register stages is combinational; all
//   operations are muxing, byte/bit permutation and 64/32-bit barrel rotation.
`timescale 1ns / 1ps

module crypto_bitmanip_alu_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  cba_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   output cba_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_wr_en,
   input  logic                     csr_wr_data
);
   import cba_pkg::*;

   logic            wide_mode_ff, wide_mode_in;
   logic            req_valid_ff, req_valid_in;
   req_payload_type req_ff, req_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;
   rsp_payload_type exec_rsp;

   assign busy = 1'b0;

   assign wide_mode_in = csr_wr_en ? csr_wr_data : wide_mode_ff;
   assign req_valid_in = start & ~busy;
   assign req_in       = req_payload;
   assign rsp_valid_in = req_valid_ff;
   assign rsp_in       = exec_rsp;

   cba_exec u_exec (
      .req       (req_ff),
      .wide_mode (wide_mode_ff),
      .rsp       (exec_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_mode_ff <= 1'b1;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wide_mode_ff <= wide_mode_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers need no reset
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/cba_checker.sv =====
// Port-level checker for crypto_bitmanip_alu_unit, attached by bind.
// Depends on cba_pkg and crypto_bitmanip_alu_unit_defines.svh.
`timescale 1ns / 1ps
`include "crypto_bitmanip_alu_unit_defines.svh"

module cba_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input cba_pkg::req_payload_type req_payload,
   input logic                     rsp_valid,
   input cba_pkg::rsp_payload_type rsp_payload,
   input logic                     csr_wr_en,
   input logic                     csr_wr_data
);
   logic accepted;

   assign accepted = start && !busy;

   // every command beat is followed by a result beat
   `CBA_ASSERT_DELAY2(a_rsp_follows_cmd, clock, reset, accepted, rsp_valid, "result beat missing")

   // no result without an earlier command beat
   `CBA_ASSERT_IMPLY(a_rsp_has_cmd, clock, reset, rsp_valid, $past(accepted, 2), "spurious result beat")

   // an illegal result carries a zero value
   `CBA_ASSERT_IMPLY(a_illegal_zero, clock, reset, rsp_valid && rsp_payload.illegal, rsp_payload.result_value == '0, "illegal result not zeroed")

   // the unit never holds off commands
   `CBA_ASSERT_ALWAYS(a_never_busy, clock, reset, !busy, "unexpected busy")

endmodule

bind crypto_bitmanip_alu_unit cba_checker u_cba_checker (.*);
